[rtl/core/ssp_pkg.sv]
package ssp_pkg;

    // Fixed-point layout
    localparam int Q_SHIFT    = 16;
    localparam int COORD_W    = 26;
    localparam int VEC_W      = 18;
    localparam int SCREEN_W   = 13;
    localparam int REL_W      = COORD_W + 1;
    localparam int PROD_W     = VEC_W + REL_W;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int DETP_W     = 2 * VEC_W;
    localparam int DET_W      = DETP_W;
    localparam int DEPTH_W    = 32;
    localparam int DIV1_NW    = MAG_W + Q_SHIFT;
    localparam int CPROD_W    = SCREEN_W + DEPTH_W + 1;
    localparam int DIV2_NW    = CPROD_W - 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_PLAYER_X      = 3'd2,
        CFG_PLAYER_Y      = 3'd3,
        CFG_DIR_X         = 3'd4,
        CFG_DIR_Y         = 3'd5,
        CFG_PLANE_X       = 3'd6,
        CFG_PLANE_Y       = 3'd7
    } cfg_idx_t;

    localparam logic [SCREEN_W-1:0]    RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [SCREEN_W-1:0]    RST_SCREEN_HEIGHT = 13'd480;
    localparam logic signed [VEC_W-1:0] RST_DIR_X        = 18'sd65536;
    localparam logic signed [VEC_W-1:0] RST_PLANE_Y      = 18'sd43254;

    typedef struct packed {
        logic [SCREEN_W-1:0]       screen_width;
        logic [SCREEN_W-1:0]       screen_height;
        logic [COORD_W-1:0]        player_x;
        logic [COORD_W-1:0]        player_y;
        logic signed [VEC_W-1:0]   dir_x;
        logic signed [VEC_W-1:0]   dir_y;
        logic signed [VEC_W-1:0]   plane_x;
        logic signed [VEC_W-1:0]   plane_y;
    } ssp_cfg_t;

    // Sideband through the camera-space divider
    typedef struct packed {
        logic tx_neg;
        logic depth_neg;
        logic det_zero;
    } ssp_side1_t;

    // Sideband through the screen-space divider
    typedef struct packed {
        logic                       center_neg;
        logic                       degen;
        logic signed [DEPTH_W-1:0]  depth;
    } ssp_side2_t;

    typedef struct packed {
        logic signed [15:0]        screen_center;
        logic [14:0]               sprite_size;
        logic [14:0]               first_column;
        logic signed [15:0]        last_column;
        logic [14:0]               first_row;
        logic signed [15:0]        last_row;
        logic signed [DEPTH_W-1:0] depth;
        logic                      degenerate;
    } ssp_res_t;

endpackage

[rtl/core/ssp_in_if.sv]
interface ssp_in_if import ssp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] sprite_x;
    logic [COORD_W-1:0] sprite_y;

    modport source (output valid, output sprite_x, output sprite_y, input ready);
    modport sink   (input valid, input sprite_x, input sprite_y, output ready);
endinterface

[rtl/core/ssp_out_if.sv]
interface ssp_out_if import ssp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [15:0]        screen_center;
    logic [14:0]               sprite_size;
    logic [14:0]               first_column;
    logic signed [15:0]        last_column;
    logic [14:0]               first_row;
    logic signed [15:0]        last_row;
    logic signed [DEPTH_W-1:0] depth;
    logic                      degenerate;

    modport source (output valid, output screen_center, output sprite_size,
                    output first_column, output last_column, output first_row,
                    output last_row, output depth, output degenerate, input ready);
    modport sink   (input valid, input screen_center, input sprite_size,
                    input first_column, input last_column, input first_row,
                    input last_row, input depth, input degenerate, output ready);
endinterface

[rtl/core/ssp_cfg_if.sv]
interface ssp_cfg_if import ssp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/ssp_div.sv]
// Restoring divider, one quotient bit per stage, two numerators over a shared divisor.
module ssp_div #(
    parameter int NW = 61,
    parameter int DW = 36,
    parameter int PW = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num_a,
    input  logic [NW-1:0] num_b,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo_a,
    output logic [NW-1:0] quo_b,
    output logic [PW-1:0] side_out
);

    logic [DW-1:0] rem_a_reg  [NW];
    logic [DW-1:0] rem_b_reg  [NW];
    logic [NW-1:0] nq_a_reg   [NW];
    logic [NW-1:0] nq_b_reg   [NW];
    logic [DW-1:0] den_reg    [NW];
    logic [PW-1:0] side_reg   [NW];
    logic          vld_reg    [NW];

    genvar k;
    for (k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] rem_a_in;
        logic [DW-1:0] rem_b_in;
        logic [NW-1:0] nq_a_in;
        logic [NW-1:0] nq_b_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] side_s;
        logic          vld_in;
        logic [DW:0]   trial_a;
        logic [DW:0]   trial_b;
        logic          ge_a;
        logic          ge_b;
        logic [DW-1:0] rem_a_next;
        logic [DW-1:0] rem_b_next;
        logic [NW-1:0] nq_a_next;
        logic [NW-1:0] nq_b_next;

        if (k == 0) begin : g_first
            assign rem_a_in = '0;
            assign rem_b_in = '0;
            assign nq_a_in  = num_a;
            assign nq_b_in  = num_b;
            assign den_in   = den;
            assign side_s   = side_in;
            assign vld_in   = in_valid;
        end
        else begin : g_next
            assign rem_a_in = rem_a_reg[k-1];
            assign rem_b_in = rem_b_reg[k-1];
            assign nq_a_in  = nq_a_reg[k-1];
            assign nq_b_in  = nq_b_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign side_s   = side_reg[k-1];
            assign vld_in   = vld_reg[k-1];
        end

        always_comb
        begin
            trial_a    = {rem_a_in, nq_a_in[NW-1]};
            trial_b    = {rem_b_in, nq_b_in[NW-1]};
            ge_a       = (trial_a >= {1'b0, den_in});
            ge_b       = (trial_b >= {1'b0, den_in});
            rem_a_next = ge_a ? DW'(trial_a - {1'b0, den_in}) : trial_a[DW-1:0];
            rem_b_next = ge_b ? DW'(trial_b - {1'b0, den_in}) : trial_b[DW-1:0];
            nq_a_next  = {nq_a_in[NW-2:0], ge_a};
            nq_b_next  = {nq_b_in[NW-2:0], ge_b};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[k] <= rem_a_next;
                rem_b_reg[k] <= rem_b_next;
                nq_a_reg[k]  <= nq_a_next;
                nq_b_reg[k]  <= nq_b_next;
                den_reg[k]   <= den_in;
                side_reg[k]  <= side_s;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quo_a     = nq_a_reg[NW-1];
    assign quo_b     = nq_b_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

[rtl/core/ssp_front.sv]
// Relative position, camera products and divider operands for tx and depth.
module ssp_front import ssp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  ssp_cfg_t           cfg_q,
    input  logic               in_valid,
    input  logic [COORD_W-1:0] sprite_x,
    input  logic [COORD_W-1:0] sprite_y,
    output logic               out_valid,
    output logic [DIV1_NW-1:0] num_tx,
    output logic [DIV1_NW-1:0] num_depth,
    output logic [DET_W-1:0]   den,
    output ssp_side1_t         side
);

    logic signed [REL_W-1:0]  rx_reg, ry_reg;
    logic signed [PROD_W-1:0] p_dyrx_reg, p_dxry_reg, p_pxry_reg, p_pyrx_reg;
    logic signed [DIFF_W-1:0] txn_reg, tyn_reg;
    logic                     vld_a_reg, vld_b_reg, vld_c_reg;

    // Determinant follows the registers on its own; it is ready when an item after a write needs it
    logic signed [DETP_W-1:0] dp1_reg, dp2_reg;
    logic signed [DETP_W:0]   det_reg;
    logic [DET_W-1:0]         detmag_reg;
    logic                     detneg_reg;
    logic                     detzero_reg;

    logic [MAG_W-1:0]         txmag;
    logic [MAG_W-1:0]         tymag;
    logic [DIFF_W-1:0]        txneg_v;
    logic [DIFF_W-1:0]        tyneg_v;
    logic [DETP_W:0]          detneg_v;

    always_ff @(posedge clk)
    begin
        dp1_reg     <= cfg_q.plane_x * cfg_q.dir_y;
        dp2_reg     <= cfg_q.dir_x * cfg_q.plane_y;
        det_reg     <= (DETP_W+1)'(dp1_reg) - (DETP_W+1)'(dp2_reg);
        detmag_reg  <= det_reg[DETP_W] ? detneg_v[DET_W-1:0] : det_reg[DET_W-1:0];
        detneg_reg  <= det_reg[DETP_W];
        detzero_reg <= (det_reg == '0);
    end

    assign detneg_v = -det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg     <= $signed({1'b0, sprite_x}) - $signed({1'b0, cfg_q.player_x});
            ry_reg     <= $signed({1'b0, sprite_y}) - $signed({1'b0, cfg_q.player_y});
            p_dyrx_reg <= cfg_q.dir_y * rx_reg;
            p_dxry_reg <= cfg_q.dir_x * ry_reg;
            p_pxry_reg <= cfg_q.plane_x * ry_reg;
            p_pyrx_reg <= cfg_q.plane_y * rx_reg;
            txn_reg    <= DIFF_W'(p_dyrx_reg) - DIFF_W'(p_dxry_reg);
            tyn_reg    <= DIFF_W'(p_pxry_reg) - DIFF_W'(p_pyrx_reg);
        end
    end

    assign txneg_v = -txn_reg;
    assign tyneg_v = -tyn_reg;
    assign txmag   = txn_reg[DIFF_W-1] ? txneg_v[MAG_W-1:0] : txn_reg[MAG_W-1:0];
    assign tymag   = tyn_reg[DIFF_W-1] ? tyneg_v[MAG_W-1:0] : tyn_reg[MAG_W-1:0];

    assign out_valid      = vld_c_reg;
    assign num_tx         = {txmag, {Q_SHIFT{1'b0}}};
    assign num_depth      = {tymag, {Q_SHIFT{1'b0}}};
    assign den            = detmag_reg;
    assign side.tx_neg    = txn_reg[DIFF_W-1] ^ detneg_reg;
    assign side.depth_neg = tyn_reg[DIFF_W-1] ^ detneg_reg;
    assign side.det_zero  = detzero_reg;

endmodule

[rtl/core/ssp_mid.sv]
// Saturate tx and depth, then form the operands for center and size.
module ssp_mid import ssp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  ssp_cfg_t           cfg_q,
    input  logic               in_valid,
    input  logic [DIV1_NW-1:0] quo_tx,
    input  logic [DIV1_NW-1:0] quo_depth,
    input  ssp_side1_t         side_in,
    output logic               out_valid,
    output logic [DIV2_NW-1:0] num_center,
    output logic [DIV2_NW-1:0] num_size,
    output logic [DEPTH_W-1:0] den,
    output ssp_side2_t         side
);

    function automatic logic [DEPTH_W-1:0] sat32(input logic [DIV1_NW-1:0] q,
                                                 input logic neg);
        logic [DEPTH_W-1:0] r;
        if (neg)
        begin
            if (q > DIV1_NW'(64'h8000_0000))
                r = 32'h8000_0000;
            else
                r = -q[DEPTH_W-1:0];
        end
        else
        begin
            if (q > DIV1_NW'(64'h7FFF_FFFF))
                r = 32'h7FFF_FFFF;
            else
                r = q[DEPTH_W-1:0];
        end
        return r;
    endfunction

    logic                      vld_e_reg, vld_f_reg, vld_g_reg;
    logic signed [DEPTH_W-1:0] tx_reg, depth_e_reg, depth_f_reg, depth_g_reg;
    logic                      degen_e_reg, degen_f_reg, degen_g_reg;
    logic signed [DEPTH_W:0]   sum_reg;
    logic [DEPTH_W-1:0]        dmag_f_reg, dmag_g_reg;
    logic                      dneg_f_reg, dneg_g_reg;
    logic signed [CPROD_W-1:0] prod_reg;

    logic [DEPTH_W-1:0]        depth_sat;
    logic [DEPTH_W-1:0]        depth_next;
    logic [DEPTH_W-1:0]        depth_neg_v;
    logic [CPROD_W-1:0]        prod_neg_v;

    always_comb
    begin
        depth_sat  = sat32(quo_depth, side_in.depth_neg);
        depth_next = side_in.det_zero ? '0 : depth_sat;
    end

    assign depth_neg_v = -depth_e_reg;
    assign prod_neg_v  = -prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_e_reg <= in_valid;
            vld_f_reg <= vld_e_reg;
            vld_g_reg <= vld_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg      <= sat32(quo_tx, side_in.tx_neg);
            depth_e_reg <= depth_next;
            degen_e_reg <= side_in.det_zero || (depth_next == '0);

            sum_reg     <= (DEPTH_W+1)'(depth_e_reg) + (DEPTH_W+1)'(tx_reg);
            dmag_f_reg  <= depth_e_reg[DEPTH_W-1] ? depth_neg_v : depth_e_reg;
            dneg_f_reg  <= depth_e_reg[DEPTH_W-1];
            depth_f_reg <= depth_e_reg;
            degen_f_reg <= degen_e_reg;

            prod_reg    <= $signed({1'b0, cfg_q.screen_width[SCREEN_W-1:1]}) * sum_reg;
            dmag_g_reg  <= dmag_f_reg;
            dneg_g_reg  <= dneg_f_reg;
            depth_g_reg <= depth_f_reg;
            degen_g_reg <= degen_f_reg;
        end
    end

    assign out_valid       = vld_g_reg;
    assign num_center      = prod_reg[CPROD_W-1] ? prod_neg_v[DIV2_NW-1:0]
                                                 : prod_reg[DIV2_NW-1:0];
    assign num_size        = DIV2_NW'({cfg_q.screen_height, {Q_SHIFT{1'b0}}});
    assign den             = dmag_g_reg;
    assign side.center_neg = prod_reg[CPROD_W-1] ^ dneg_g_reg;
    assign side.degen      = degen_g_reg;
    assign side.depth      = depth_g_reg;

endmodule

[rtl/core/ssp_finish.sv]
// Saturate center and size, then clamp the column and row span.
module ssp_finish import ssp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  ssp_cfg_t           cfg_q,
    input  logic               in_valid,
    input  logic [DIV2_NW-1:0] quo_center,
    input  logic [DIV2_NW-1:0] quo_size,
    input  ssp_side2_t         side_in,
    output logic               out_valid,
    output ssp_res_t           res
);

    logic                      vld_reg;
    logic signed [15:0]        center_reg;
    logic [14:0]               size_reg;
    logic                      degen_reg;
    logic signed [DEPTH_W-1:0] depth_reg;

    logic [15:0]               center_next;
    logic [14:0]               size_next;
    logic [13:0]               half;
    logic [11:0]               hh;
    logic signed [17:0]        r0, c0, c1;
    logic [17:0]               r1;

    always_comb
    begin
        if (side_in.center_neg)
            center_next = (quo_center > DIV2_NW'(32768)) ? 16'h8000 : -quo_center[15:0];
        else
            center_next = (quo_center > DIV2_NW'(32767)) ? 16'h7FFF : quo_center[15:0];
        size_next = (quo_size > DIV2_NW'(32767)) ? 15'h7FFF : quo_size[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            center_reg <= center_next;
            size_reg   <= size_next;
            degen_reg  <= side_in.degen;
            depth_reg  <= side_in.depth;
        end
    end

    always_comb
    begin
        half = size_reg[14:1];
        hh   = cfg_q.screen_height[SCREEN_W-1:1];
        r0   = $signed({6'b0, hh}) - $signed({4'b0, half});
        r1   = {6'b0, hh} + {4'b0, half};
        c0   = 18'(center_reg) - $signed({4'b0, half});
        c1   = 18'(center_reg) + $signed({4'b0, half});

        res.depth      = depth_reg;
        res.degenerate = degen_reg;
        if (degen_reg)
        begin
            res.screen_center = '0;
            res.sprite_size   = '0;
            res.first_column  = '0;
            res.last_column   = '0;
            res.first_row     = '0;
            res.last_row      = '0;
        end
        else
        begin
            res.screen_center = center_reg;
            res.sprite_size   = size_reg;
            res.first_row     = r0[17] ? 15'd0 : r0[14:0];
            res.last_row      = (r1 >= {5'b0, cfg_q.screen_height})
                                ? 16'({3'b0, cfg_q.screen_height}) - 16'd1 : r1[15:0];
            res.first_column  = c0[17] ? 15'd0 : c0[14:0];
            res.last_column   = (c1 >= $signed({5'b0, cfg_q.screen_width}))
                                ? 16'({3'b0, cfg_q.screen_width}) - 16'd1 : c1[15:0];
        end
    end

    assign out_valid = vld_reg;

endmodule

[rtl/core/ssp_outq.sv]
// Two-word output queue; the pipeline holds when it is full.
module ssp_outq import ssp_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  ssp_res_t push_data,
    output logic     space,
    output logic     out_valid,
    output ssp_res_t out_data,
    input  logic     out_ready
);

    ssp_res_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign space     = (count_reg != 2'd2);
    assign push      = space && push_valid;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/core/sprite_screen_projection.sv]
// Sprite screen projection: each sprite word (map x, y in Q10.16) is moved into
// camera space with the inverse camera matrix, then mapped to a screen column,
// a square on-screen size and a clamped column and row span. One word enters
// per clock while the output queue has space, and one result word leaves per
// clock while the consumer is ready. It is built on two restoring dividers:
// a 61-stage one for tx and depth, which share the determinant, and a 45-stage
// one for the center column and the size, which share |depth|. A two-word queue
// at the end absorbs a stalled consumer; the whole pipeline holds only when it
// is full. Configuration writes are registered and are meant for an idle
// block; the determinant is recomputed from the registers after a write.
// A zero determinant or a zero depth raises degenerate and zeroes the geometry.
module sprite_screen_projection import ssp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ssp_cfg_if.sink     cfg,
    ssp_in_if.sink      sprite,
    ssp_out_if.source   result
);

    ssp_cfg_t           cfg_reg;
    logic               en;

    logic               f_valid;
    logic [DIV1_NW-1:0] f_num_tx, f_num_depth;
    logic [DET_W-1:0]   f_den;
    ssp_side1_t         f_side;

    logic               d1_valid;
    logic [DIV1_NW-1:0] d1_tx, d1_depth;
    logic [$bits(ssp_side1_t)-1:0] d1_side;

    logic               m_valid;
    logic [DIV2_NW-1:0] m_num_center, m_num_size;
    logic [DEPTH_W-1:0] m_den;
    ssp_side2_t         m_side;

    logic               d2_valid;
    logic [DIV2_NW-1:0] d2_center, d2_size;
    logic [$bits(ssp_side2_t)-1:0] d2_side;

    logic               fin_valid;
    ssp_res_t           fin_res;
    ssp_res_t           q_res;

    // Configuration registers, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.player_x      <= '0;
            cfg_reg.player_y      <= '0;
            cfg_reg.dir_x         <= RST_DIR_X;
            cfg_reg.dir_y         <= '0;
            cfg_reg.plane_x       <= '0;
            cfg_reg.plane_y       <= RST_PLANE_Y;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg.data[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg.data[SCREEN_W-1:0];
                CFG_PLAYER_X:      cfg_reg.player_x      <= cfg.data[COORD_W-1:0];
                CFG_PLAYER_Y:      cfg_reg.player_y      <= cfg.data[COORD_W-1:0];
                CFG_DIR_X:         cfg_reg.dir_x         <= cfg.data[VEC_W-1:0];
                CFG_DIR_Y:         cfg_reg.dir_y         <= cfg.data[VEC_W-1:0];
                CFG_PLANE_X:       cfg_reg.plane_x       <= cfg.data[VEC_W-1:0];
                CFG_PLANE_Y:       cfg_reg.plane_y       <= cfg.data[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    // Every stage advances together unless the output queue is full
    assign sprite.ready = en;

    // Relative position, camera products, divider operands
    ssp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg_q     (cfg_reg),
        .in_valid  (sprite.valid),
        .sprite_x  (sprite.sprite_x),
        .sprite_y  (sprite.sprite_y),
        .out_valid (f_valid),
        .num_tx    (f_num_tx),
        .num_depth (f_num_depth),
        .den       (f_den),
        .side      (f_side)
    );

    // tx and depth over the determinant
    ssp_div #(
        .NW (DIV1_NW),
        .DW (DET_W),
        .PW ($bits(ssp_side1_t))
    ) u_div_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .num_a     (f_num_tx),
        .num_b     (f_num_depth),
        .den       (f_den),
        .side_in   (f_side),
        .out_valid (d1_valid),
        .quo_a     (d1_tx),
        .quo_b     (d1_depth),
        .side_out  (d1_side)
    );

    // Saturation and center product
    ssp_mid u_mid (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg_q      (cfg_reg),
        .in_valid   (d1_valid),
        .quo_tx     (d1_tx),
        .quo_depth  (d1_depth),
        .side_in    (ssp_side1_t'(d1_side)),
        .out_valid  (m_valid),
        .num_center (m_num_center),
        .num_size   (m_num_size),
        .den        (m_den),
        .side       (m_side)
    );

    // Center column and size over |depth|
    ssp_div #(
        .NW (DIV2_NW),
        .DW (DEPTH_W),
        .PW ($bits(ssp_side2_t))
    ) u_div_scr (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .num_a     (m_num_center),
        .num_b     (m_num_size),
        .den       (m_den),
        .side_in   (m_side),
        .out_valid (d2_valid),
        .quo_a     (d2_center),
        .quo_b     (d2_size),
        .side_out  (d2_side)
    );

    // Screen clamps
    ssp_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg_q      (cfg_reg),
        .in_valid   (d2_valid),
        .quo_center (d2_center),
        .quo_size   (d2_size),
        .side_in    (ssp_side2_t'(d2_side)),
        .out_valid  (fin_valid),
        .res        (fin_res)
    );

    // Output queue decouples the consumer from the pipeline
    ssp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fin_valid),
        .push_data  (fin_res),
        .space      (en),
        .out_valid  (result.valid),
        .out_data   (q_res),
        .out_ready  (result.ready)
    );

    assign result.screen_center = q_res.screen_center;
    assign result.sprite_size   = q_res.sprite_size;
    assign result.first_column  = q_res.first_column;
    assign result.last_column   = q_res.last_column;
    assign result.first_row     = q_res.first_row;
    assign result.last_row      = q_res.last_row;
    assign result.depth         = q_res.depth;
    assign result.degenerate    = q_res.degenerate;

    // Input may only hold while a finished word waits at the output
    a_hold_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !sprite.ready |-> result.valid)
        else $error("input held with no result pending");

    // A degenerate word carries no geometry
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.degenerate |->
            result.sprite_size == '0 && result.screen_center == '0 &&
            result.first_column == '0 && result.last_row == '0)
        else $error("degenerate result carries geometry");

    // The end row never passes the screen edge
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.degenerate |->
            result.last_row < $signed({3'b0, cfg_reg.screen_height}))
        else $error("last row beyond screen height");

    // The start row never passes the screen middle
    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            result.first_row <= {3'b0, cfg_reg.screen_height[SCREEN_W-1:1]})
        else $error("first row below screen middle");

endmodule

[test/sprite_screen_projection_test.sv]
`timescale 1ns / 100ps

module sprite_screen_projection_test;
    import ssp_pkg::*;

    // Projection scoreboard: holds its own copy of the camera registers,
    // projects every accepted sprite word and checks results in order.
    class projection_board;
        ssp_cfg_t  cam;
        ssp_res_t  pending_q[$];
        int        mismatches;

        function new();
            cam.screen_width  = RST_SCREEN_WIDTH;
            cam.screen_height = RST_SCREEN_HEIGHT;
            cam.player_x      = '0;
            cam.player_y      = '0;
            cam.dir_x         = RST_DIR_X;
            cam.dir_y         = '0;
            cam.plane_x       = '0;
            cam.plane_y       = RST_PLANE_Y;
            mismatches        = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SCREEN_WIDTH:  cam.screen_width  = val[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT: cam.screen_height = val[SCREEN_W-1:0];
                CFG_PLAYER_X:      cam.player_x      = val[COORD_W-1:0];
                CFG_PLAYER_Y:      cam.player_y      = val[COORD_W-1:0];
                CFG_DIR_X:         cam.dir_x         = val[VEC_W-1:0];
                CFG_DIR_Y:         cam.dir_y         = val[VEC_W-1:0];
                CFG_PLANE_X:       cam.plane_x       = val[VEC_W-1:0];
                CFG_PLANE_Y:       cam.plane_y       = val[VEC_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        // Invert the camera matrix, then map depth to column, size and spans
        function void note_sprite(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
            longint rx, ry, dx, dy, px, py, w, h, det;
            longint tx, dep, center, size, half, c0, c1, r0, r1;
            ssp_res_t e;
            rx = longint'(sx) - longint'(cam.player_x);
            ry = longint'(sy) - longint'(cam.player_y);
            dx = cam.dir_x;
            dy = cam.dir_y;
            px = cam.plane_x;
            py = cam.plane_y;
            w  = cam.screen_width;
            h  = cam.screen_height;
            det = px * dy - dx * py;
            dep = 0; center = 0; size = 0; c0 = 0; c1 = 0; r0 = 0; r1 = 0;
            e.degenerate = 1'b1;
            if (det != 0) begin
                tx  = clip((dy * rx - dx * ry) * 65536 / det, -(64'sd1 <<< 31),
                           (64'sd1 <<< 31) - 1);
                dep = clip((px * ry - py * rx) * 65536 / det, -(64'sd1 <<< 31),
                           (64'sd1 <<< 31) - 1);
                if (dep != 0) begin
                    e.degenerate = 1'b0;
                    center = clip((w / 2) * (dep + tx) / dep, -32768, 32767);
                    size = h * 65536 / dep;
                    if (size < 0)
                        size = -size;
                    size = clip(size, 0, 32767);
                    half = size / 2;
                    r0 = h / 2 - half;
                    if (r0 < 0)
                        r0 = 0;
                    r1 = half + h / 2;
                    if (r1 >= h)
                        r1 = h - 1;
                    c0 = center - half;
                    if (c0 < 0)
                        c0 = 0;
                    c1 = half + center;
                    if (c1 >= w)
                        c1 = w - 1;
                end
            end
            e.screen_center = center[15:0];
            e.sprite_size   = size[14:0];
            e.first_column  = c0[14:0];
            e.last_column   = c1[15:0];
            e.first_row     = r0[14:0];
            e.last_row      = r1[15:0];
            e.depth         = dep[31:0];
            pending_q.push_back(e);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_result(ssp_res_t r);
            ssp_res_t e;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
                return;
            end
            e = pending_q.pop_front();
            if (r.screen_center !== e.screen_center)
                report_mismatch("screen_center", r.screen_center, e.screen_center);
            if (r.sprite_size !== e.sprite_size)
                report_mismatch("sprite_size", r.sprite_size, e.sprite_size);
            if (r.first_column !== e.first_column)
                report_mismatch("first_column", r.first_column, e.first_column);
            if (r.last_column !== e.last_column)
                report_mismatch("last_column", r.last_column, e.last_column);
            if (r.first_row !== e.first_row)
                report_mismatch("first_row", r.first_row, e.first_row);
            if (r.last_row !== e.last_row)
                report_mismatch("last_row", r.last_row, e.last_row);
            if (r.depth !== e.depth)
                report_mismatch("depth", r.depth, e.depth);
            if (r.degenerate !== e.degenerate)
                report_mismatch("degenerate", r.degenerate, e.degenerate);
        endtask
    endclass

    logic clk;
    logic rst_n;

    ssp_cfg_if cfg_bus ();
    ssp_in_if  sprite_bus ();
    ssp_out_if result_bus ();

    sprite_screen_projection uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus.sink),
        .sprite (sprite_bus.sink),
        .result (result_bus.source)
    );

    projection_board board;

    // Idle modes: steady means no gaps on that side for the current phase
    bit src_steady;
    bit sink_steady;
    bit hold_sink;

    always #5 clk = ~clk;

    // Drain: sample accepted result words at the rising edge
    always @(posedge clk) begin
        ssp_res_t r;
        if (rst_n && result_bus.valid && result_bus.ready) begin
            r.screen_center = result_bus.screen_center;
            r.sprite_size   = result_bus.sprite_size;
            r.first_column  = result_bus.first_column;
            r.last_column   = result_bus.last_column;
            r.first_row     = result_bus.first_row;
            r.last_row      = result_bus.last_row;
            r.depth         = result_bus.depth;
            r.degenerate    = result_bus.degenerate;
            board.check_result(r);
        end
    end

    // Result consumer: random stalls, plus one long hold-off on request so
    // the pipeline fills and backs up into the sprite input
    initial begin
        int stall;
        result_bus.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_sink) begin
                result_bus.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_sink = 1'b0;
            end else begin
                stall = sink_steady ? 0 : $urandom_range(0, 16);
                if (stall > 0) begin
                    result_bus.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (!result_bus.valid);
        end
    end

    // Write one camera register; only called with the block idle
    task write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        repeat ($urandom_range(0, 16)) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        board.set_reg(idx, val);
        cfg_bus.valid <= 1'b0;
    endtask

    // Offer one sprite word; keep valid high across back-to-back words
    task send_sprite(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            sprite_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sprite_bus.valid    <= 1'b1;
        sprite_bus.sprite_x <= sx;
        sprite_bus.sprite_y <= sy;
        do @(posedge clk); while (!sprite_bus.ready);
        board.note_sprite(sx, sy);
    endtask

    // Drop valid and hold until every expected word has come back
    task drain_all();
        sprite_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_q.size() != 0)
            @(posedge clk);
    endtask

    function logic [VEC_W-1:0] rand_vec();
        case ($urandom_range(0, 3))
            0: return VEC_W'($urandom);
            1: return $urandom_range(0, 1) ? 18'h20000 : 18'h1FFFF;
            default: return VEC_W'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // Load a full camera setup; some phases pin the extremes
    task load_phase(int p);
        logic [SCREEN_W-1:0] w, h;
        logic [VEC_W-1:0]    dx, dy, px, py;
        logic [COORD_W-1:0]  plx, ply;
        w   = SCREEN_W'($urandom_range(1, 4096));
        h   = SCREEN_W'($urandom_range(1, 4096));
        plx = COORD_W'($urandom);
        ply = COORD_W'($urandom);
        dx  = rand_vec();
        dy  = rand_vec();
        px  = rand_vec();
        py  = rand_vec();
        case (p)
            1: begin w = 13'd1; h = 13'd1; plx = '0; ply = '0; end
            2: begin w = 13'd4096; h = 13'd4096; plx = '1; ply = '1; end
            3: begin w = 13'd0; h = 13'd0; end
            4: begin w = 13'd8191; h = 13'd8191; end
            5: begin px = dx; py = dy; end  // parallel plane: zero determinant
            6: begin dx = 18'h20000; dy = 18'h1FFFF; px = 18'h1FFFF; py = 18'h20000; end
            7: begin dx = 18'd65536; dy = '0; px = '0; py = 18'd43254; end
            default: ;
        endcase
        write_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_SCREEN_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_PLAYER_X, plx);
        write_reg(CFG_PLAYER_Y, ply);
        write_reg(CFG_DIR_X, CFG_DATA_W'(dx));
        write_reg(CFG_DIR_Y, CFG_DATA_W'(dy));
        write_reg(CFG_PLANE_X, CFG_DATA_W'(px));
        write_reg(CFG_PLANE_Y, CFG_DATA_W'(py));
        // let the determinant settle after the last write
        repeat (6) @(posedge clk);
    endtask

    // Mostly sprites near the camera so sizes and spans are meaningful
    task send_random(int n);
        logic [COORD_W-1:0] sx, sy;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                sx = COORD_W'($urandom);
                sy = COORD_W'($urandom);
            end else begin
                sx = board.cam.player_x + COORD_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
                sy = board.cam.player_y + COORD_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            end
            send_sprite(sx, sy);
        end
    endtask

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_SCREEN_WIDTH;
        cfg_bus.data = '0;
        sprite_bus.valid = 1'b0;
        sprite_bus.sprite_x = '0;
        sprite_bus.sprite_y = '0;
        src_steady = 1'b0;
        sink_steady = 1'b0;
        hold_sink = 1'b0;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words on the reset camera: at the player (zero depth),
        // field extremes, ahead, very near (size saturates), far away
        send_sprite('0, '0);
        send_sprite('1, '1);
        send_sprite('1, '0);
        send_sprite('0, '1);
        send_sprite(26'd131072, '0);
        send_sprite(26'd65536, 26'd32768);
        send_sprite(26'd1, '0);
        send_sprite(26'd2, 26'd1);
        send_sprite(26'd655360, 26'd655360);
        send_sprite(26'h2AAAAAA, 26'h1555555);
        send_sprite(26'h1555555, 26'h2AAAAAA);
        send_sprite(26'd65536, '0);
        send_sprite('0, 26'd65536);
        drain_all();

        // Camera moved forward: sprites behind it (negative depth), one ahead and one at the player
        write_reg(CFG_PLAYER_X, 26'd655360);
        write_reg(CFG_PLAYER_Y, 26'd655360);
        repeat (6) @(posedge clk);
        send_sprite(26'd393216, 26'd655360);
        send_sprite(26'd655359, 26'd655360);
        send_sprite(26'd720896, 26'd700000);
        send_sprite(26'd655360, 26'd655360);
        drain_all();

        for (int p = 1; p <= 10; p++) begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            load_phase(p);
            if (p == 2) begin
                // long consumer hold-off while words keep coming; send more
                // words than the pipeline holds so the input backs up
                src_steady = 1'b1;
                hold_sink = 1'b1;
            end
            send_random(p == 2 ? 200 : 103);
            drain_all();
        end

        repeat (150) @(posedge clk);
        if (board.mismatches == 0 && board.pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
